// ===== src/ts_rs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ts_rs_pkg
// Shared types and constants of the transport stream timestamp restamper:
// packet geometry, header byte positions, field kinds and the run record
// that carries the result bytes of one input byte between the stages.
// ----------------------------------------------------------------------------
package ts_rs_pkg;

	localparam int PACKET_BYTES = 188;
	localparam int IDX_W        = 8;   // byte index inside a packet
	localparam int POS_W        = 9;   // PES header position and field bounds
	localparam int HOLD_DEPTH   = 6;   // longest timestamp field (PCR)
	localparam int CNT_W        = 3;
	localparam int BASE_W       = 33;  // 90 kHz timestamp base

	// header byte positions
	localparam logic [IDX_W-1:0] HDR_PUSI_BYTE = IDX_W'(1);
	localparam logic [IDX_W-1:0] HDR_AFC_BYTE  = IDX_W'(3);
	localparam logic [IDX_W-1:0] AF_LEN_BYTE   = IDX_W'(4);
	localparam logic [IDX_W-1:0] AF_FLAGS_BYTE = IDX_W'(5);
	localparam logic [IDX_W-1:0] LAST_BYTE     = IDX_W'(PACKET_BYTES - 1);

	// PCR field
	localparam logic [POS_W-1:0] PCR_START = POS_W'(6);
	localparam logic [POS_W-1:0] PCR_END   = POS_W'(12);
	localparam logic [CNT_W-1:0] PCR_LEN   = CNT_W'(6);
	localparam logic [8:0]       PCR_MIN_AF_SIZE = 9'd8;

	// PES header layout relative to its start
	localparam logic [POS_W-1:0] PES_NO_AF_POS  = POS_W'(4);
	localparam logic [POS_W-1:0] PES_AF_BASE    = POS_W'(5);
	localparam logic [POS_W-1:0] PES_AF_LIMIT   = POS_W'(PACKET_BYTES - 14);
	localparam logic [POS_W-1:0] PES_FLAGS_OFS  = POS_W'(7);
	localparam logic [POS_W-1:0] PTS_OFS        = POS_W'(9);
	localparam logic [POS_W-1:0] DTS_OFS        = POS_W'(14);
	localparam logic [POS_W-1:0] DTS_END_OFS    = POS_W'(19);
	localparam logic [POS_W-1:0] PTS_MAX_POS    = POS_W'(PACKET_BYTES - 14);
	localparam logic [POS_W-1:0] DTS_MAX_POS    = POS_W'(PACKET_BYTES - 19);
	localparam logic [CNT_W-1:0] TS_LEN         = CNT_W'(5);

	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_PCR  = 2'd1,
		KIND_PTS  = 2'd2,
		KIND_DTS  = 2'd3
	} kind_t;

	typedef enum logic {
		REG_TIME_OFFSET = 1'b0,
		REG_PTS_SHIFT   = 1'b1
	} reg_idx_t;

	localparam int APB_ADDR_W = 3;

	// Result bytes caused by one input byte; entries 0..count-1 are sent.
	typedef struct packed {
		logic [HOLD_DEPTH-1:0][7:0] data;
		logic [HOLD_DEPTH-1:0]      pkt_first;
		kind_t                      fkind;
		logic [CNT_W-1:0]           count;
	} run_t;

endpackage
`default_nettype wire

// ===== src/ts_rs_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ts_rs_parser
// Tracks the packet position and header flags, holds timestamp bytes and
// builds the run of result bytes for each accepted stream byte.
// ----------------------------------------------------------------------------
module ts_rs_parser
	import ts_rs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       packet_begin,
	input  logic       s1_free,
	output run_t       run_s1,
	output logic       run_valid_s1
);

	logic [IDX_W-1:0] byte_index_q;
	logic [1:0]       hdr_flags_q;
	logic [8:0]       adapt_size_q;
	logic [POS_W-1:0] pes_pos_q;
	logic [2:0]       pes_flags_q;
	logic [7:0]       hold_q [HOLD_DEPTH];
	logic [CNT_W-1:0] hold_count_q;
	kind_t            hold_kind_q;

	logic             accept;
	logic [IDX_W-1:0] idx;
	logic [POS_W-1:0] idx9;
	logic             first;
	logic [1:0]       hf;
	logic [8:0]       asz;
	logic [POS_W-1:0] p;
	logic [POS_W-1:0] pn;
	logic [2:0]       pf;
	kind_t            kind;
	logic [POS_W-1:0] start;
	logic [CNT_W-1:0] len;
	logic             flush;
	logic [CNT_W-1:0] pos;
	logic             complete;
	logic             hold_we;
	logic [CNT_W-1:0] hold_count_n;
	kind_t            hold_kind_n;
	logic [IDX_W-1:0] byte_index_n;
	run_t             run;

	assign accept   = in_valid && in_ready;
	assign in_ready = !run_valid_s1 || s1_free;

	always_comb begin
		idx   = (packet_begin || byte_index_q > LAST_BYTE) ? '0 : byte_index_q;
		idx9  = {1'b0, idx};
		first = (idx == '0);
		hf    = first ? '0 : hdr_flags_q;
		asz   = first ? '0 : adapt_size_q;
		p     = first ? '0 : pes_pos_q;
		pf    = first ? '0 : pes_flags_q;

		// transport header and adaptation field
		if (idx == HDR_PUSI_BYTE) begin
			if (in_byte[6])
				hf[0] = 1'b1;
		end else if (idx == HDR_AFC_BYTE) begin
			if (in_byte[5])
				hf[1] = 1'b1;
			else if (hf[0])
				p = PES_NO_AF_POS;
		end else if (idx == AF_LEN_BYTE && hf[1]) begin
			asz = 9'd1 + {1'b0, in_byte};
			if (hf[0] && {1'b0, in_byte} < PES_AF_LIMIT)
				p = PES_AF_BASE + {1'b0, in_byte};
		end else if (idx == AF_FLAGS_BYTE && hf[1]) begin
			if (in_byte[4] && asz >= PCR_MIN_AF_SIZE)
				pf[0] = 1'b1;
		end

		// PES start prefix and PTS/DTS flags
		pn = p;
		if (p != '0) begin
			if ((idx9 == p || idx9 == p + POS_W'(1)) && in_byte != 8'h00)
				pn = '0;
			else if (idx9 == p + POS_W'(2) && in_byte != 8'h01)
				pn = '0;
			else if (idx9 == p + PES_FLAGS_OFS && in_byte[7] && p <= PTS_MAX_POS) begin
				pf[1] = 1'b1;
				if (in_byte[6] && p <= DTS_MAX_POS)
					pf[2] = 1'b1;
			end
		end

		// field classification
		kind  = KIND_PASS;
		start = '0;
		len   = '0;
		if (pf[0] && idx9 >= PCR_START && idx9 < PCR_END) begin
			kind  = KIND_PCR;
			start = PCR_START;
			len   = PCR_LEN;
		end else if (p != '0 && pf[1] && idx9 >= p + PTS_OFS && idx9 < p + DTS_OFS) begin
			kind  = KIND_PTS;
			start = p + PTS_OFS;
			len   = TS_LEN;
		end else if (p != '0 && pf[2] && idx9 >= p + DTS_OFS && idx9 < p + DTS_END_OFS) begin
			kind  = KIND_DTS;
			start = p + DTS_OFS;
			len   = TS_LEN;
		end

		// release held bytes unchanged on restart or an interrupted field
		flush    = (hold_count_q != '0) &&
			(first || hold_kind_q != kind || idx9 == start);
		pos      = flush ? '0 : hold_count_q;
		complete = (kind != KIND_PASS) && (pos + CNT_W'(1) == len);
		hold_we  = (kind != KIND_PASS) && !complete;

		if (hold_we) begin
			hold_count_n = pos + CNT_W'(1);
			hold_kind_n  = kind;
		end else begin
			hold_count_n = '0;
			hold_kind_n  = KIND_PASS;
		end

		// held bytes occupy the front of the run, this byte follows them
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			run.data[i]      = (CNT_W'(i) == hold_count_q) ? in_byte : hold_q[i];
			run.pkt_first[i] = (CNT_W'(i) == hold_count_q) && first;
		end
		run.fkind = complete ? kind : KIND_PASS;
		if (complete)
			run.count = len;
		else if (kind == KIND_PASS)
			run.count = hold_count_q + CNT_W'(1);
		else if (flush)
			run.count = hold_count_q;
		else
			run.count = '0;

		byte_index_n = (idx == LAST_BYTE) ? '0 : idx + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			hdr_flags_q  <= '0;
			adapt_size_q <= '0;
			pes_pos_q    <= '0;
			pes_flags_q  <= '0;
			hold_count_q <= '0;
			hold_kind_q  <= KIND_PASS;
			run_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				byte_index_q <= byte_index_n;
				hdr_flags_q  <= hf;
				adapt_size_q <= asz;
				pes_pos_q    <= pn;
				pes_flags_q  <= pf;
				hold_count_q <= hold_count_n;
				hold_kind_q  <= hold_kind_n;
				run_valid_s1 <= (run.count != '0);
			end else if (s1_free) begin
				run_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1 <= run;
			if (hold_we) begin
				for (int i = 0; i < HOLD_DEPTH; i++) begin
					if (CNT_W'(i) == pos)
						hold_q[i] <= in_byte;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/ts_rs_rewrite.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ts_rs_rewrite
// Adds the offset to the 33-bit base of a completed PCR, PTS or DTS run and
// packs the new base back, keeping marker, reserved and extension bits.
// ----------------------------------------------------------------------------
module ts_rs_rewrite
	import ts_rs_pkg::*;
(
	input  run_t              run_in,
	input  logic [BASE_W-1:0] time_off,
	input  logic [BASE_W-1:0] pts_off,
	output run_t              run_out
);

	logic [BASE_W-1:0] base;
	logic [BASE_W-1:0] off;
	logic [BASE_W-1:0] nbase;

	always_comb begin
		if (run_in.fkind == KIND_PCR)
			base = {run_in.data[0], run_in.data[1], run_in.data[2],
				run_in.data[3], run_in.data[4][7]};
		else
			base = {run_in.data[0][3:1], run_in.data[1], run_in.data[2][7:1],
				run_in.data[3], run_in.data[4][7:1]};

		off   = (run_in.fkind == KIND_PTS) ? pts_off : time_off;
		nbase = base + off;

		run_out = run_in;
		case (run_in.fkind)
			KIND_PCR: begin
				run_out.data[0] = nbase[32:25];
				run_out.data[1] = nbase[24:17];
				run_out.data[2] = nbase[16:9];
				run_out.data[3] = nbase[8:1];
				run_out.data[4] = {nbase[0], run_in.data[4][6:0]};
			end
			KIND_PTS, KIND_DTS: begin
				run_out.data[0] = {run_in.data[0][7:4], nbase[32:30], run_in.data[0][0]};
				run_out.data[1] = nbase[29:22];
				run_out.data[2] = {nbase[21:15], run_in.data[2][0]};
				run_out.data[3] = nbase[14:7];
				run_out.data[4] = {nbase[6:0], run_in.data[4][0]};
			end
			default: begin
				run_out = run_in;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/ts_rs_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ts_rs_serializer
// Holds the run being sent and hands its bytes out one per transaction.
// ----------------------------------------------------------------------------
module ts_rs_serializer
	import ts_rs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  run_t       run_in,
	input  logic       run_valid,
	output logic       s1_free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_begin,
	output logic       run_last,
	output logic [1:0] field_kind
);

	run_t             cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] pos_q;

	assign out_valid  = cur_valid_q;
	assign out_byte   = cur_q.data[pos_q];
	assign out_begin  = cur_q.pkt_first[pos_q];
	assign field_kind = cur_q.fkind;
	assign run_last   = (pos_q == cur_q.count - CNT_W'(1));
	assign s1_free    = !cur_valid_q || (out_ready && run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (s1_free) begin
				cur_valid_q <= run_valid;
				pos_q       <= '0;
			end else if (out_ready) begin
				pos_q <= pos_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && run_valid)
			cur_q <= run_in;
	end

endmodule
`default_nettype wire

// ===== src/ts_timestamp_restamper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ts_timestamp_restamper
// PCR/PTS/DTS restamper for an aligned 188-byte MPEG transport stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per transaction and normally gives one byte
// out for it, through the parser's and serializer's registers. Bytes of a PCR
// (6 bytes), PTS or DTS (5 bytes each) are held back; the byte that completes
// a field releases the whole field, with its 33-bit base advanced by
// time_offset (plus the PTS shift for the PTS) modulo 2^33, as a burst that
// leaves at one byte per cycle while the output is taken. Plain bytes flow
// in at one byte per cycle as long as the output is taken; a burst occupies
// the serializer, the next byte waits in the parser's result register and
// the input stalls until the burst has left. A packet_begin that cuts a
// packet short sends any held bytes first, unchanged and marked as plain
// bytes. run_last flags the last output byte caused by one input byte.
// Registers (APB, 32-bit): 0x0 time_offset, 0x4 PTS shift, both signed.
// Write them only while no stream data is in flight.
// ----------------------------------------------------------------------------
module ts_timestamp_restamper
	import ts_rs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// stream in
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  packet_begin,
	// stream out
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_begin,
	output logic                  run_last,
	output logic [1:0]            field_kind,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [31:0]       time_offset_q;
	logic [31:0]       pts_shift_q;
	logic [BASE_W-1:0] pts_off_q;
	logic [BASE_W-1:0] time_off;
	logic              cfg_wr;
	reg_idx_t          reg_sel;

	run_t run_s1;
	logic run_valid_s1;
	run_t run_rw;
	logic s1_free;

	// Register file: the PTS offset sum is kept ready so the datapath sees a
	// single add per field.
	assign pready   = 1'b1;
	assign reg_sel  = reg_idx_t'(paddr[2]);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign time_off = {time_offset_q[31], time_offset_q};

	always_comb begin
		case (reg_sel)
			REG_TIME_OFFSET: prdata = time_offset_q;
			REG_PTS_SHIFT:   prdata = pts_shift_q;
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_offset_q <= '0;
			pts_shift_q   <= '0;
			pts_off_q     <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_TIME_OFFSET: begin
					time_offset_q <= pwdata;
					pts_off_q     <= {pwdata[31], pwdata} + {pts_shift_q[31], pts_shift_q};
				end
				REG_PTS_SHIFT: begin
					pts_shift_q <= pwdata;
					pts_off_q   <= {time_offset_q[31], time_offset_q} + {pwdata[31], pwdata};
				end
				default: begin
					pts_off_q <= pts_off_q;
				end
			endcase
		end
	end

	// Parse the header, hold field bytes and register the run of each byte.
	ts_rs_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.packet_begin (packet_begin),
		.s1_free      (s1_free),
		.run_s1       (run_s1),
		.run_valid_s1 (run_valid_s1)
	);

	// Advance the timestamp base on the way into the output stage.
	ts_rs_rewrite u_rewrite (
		.run_in   (run_s1),
		.time_off (time_off),
		.pts_off  (pts_off_q),
		.run_out  (run_rw)
	);

	// Drain each run one byte per output transaction.
	ts_rs_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_in     (run_rw),
		.run_valid  (run_valid_s1),
		.s1_free    (s1_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_begin  (out_begin),
		.run_last   (run_last),
		.field_kind (field_kind)
	);

endmodule
`default_nettype wire

// ===== src/ts_rs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ts_rs_checker
// Port-level checks of the restamper output stream, bound to the top level.
// ----------------------------------------------------------------------------
module ts_rs_checker
	import ts_rs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_begin,
	input logic       run_last,
	input logic [1:0] field_kind,
	input logic       pready
);

	// hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_begin))
		else $error("output transaction changed while stalled");

	// packet start byte is always a plain byte closing its run
	a_begin_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_begin |-> run_last && field_kind == KIND_PASS)
		else $error("packet start byte inside a run or a timestamp field");

	// a run of timestamp bytes leaves back to back with one kind
	a_run_contig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last && field_kind != KIND_PASS
		|=> out_valid && field_kind == $past(field_kind))
		else $error("timestamp run broken");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ts_timestamp_restamper ts_rs_checker u_ts_rs_checker (.*);
`default_nettype wire

// ===== verif/tb_ts_timestamp_restamper.sv =====
// ----------------------------------------------------------------------------
// tb_ts_timestamp_restamper
// Self-checking bench for the transport stream PCR/PTS/DTS restamper. A short
// directed table covers stream start, a wrapping PCR and a packet cut in the
// middle of a PCR. Random packets follow, most with well-formed headers and
// PES headers, half with adaptation fields, many cut short. Some PES headers
// sit near the packet end, and some packets carry broken prefixes or stray
// packet starts. A bit-accurate predictor checks every output transaction.
// ----------------------------------------------------------------------------
module tb_ts_timestamp_restamper
	import ts_rs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 16;   // covers pipeline plus a full field burst
	localparam int STALL_LIMIT  = 2000; // cycles with no transaction on either side
	localparam int PHASE_ITEMS  = 50;

	// one output transaction
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		kind_t      kind;
	} out_rec_t;

	// one input transaction, with an optional hand-written expectation
	typedef struct packed {
		logic [7:0] b;
		logic       beg;
		logic       typed;
		logic [7:0] x_byte;
		logic       x_first;
		kind_t      x_kind;
	} stim_row_t;

	// Directed table, run with time_offset = +1 and PTS shift = -1.
	// Typed rows expect a single plain byte closing its run.
	localparam stim_row_t DIRECTED [22] = '{
		// stream start: byte 0 arrives without packet_begin
		'{8'h47, 1'b0, 1'b1, 8'h47, 1'b1, KIND_PASS},
		'{8'h40, 1'b0, 1'b1, 8'h40, 1'b0, KIND_PASS}, // payload unit start
		'{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, KIND_PASS},
		'{8'h30, 1'b0, 1'b1, 8'h30, 1'b0, KIND_PASS}, // adaptation field + payload
		'{8'h07, 1'b0, 1'b1, 8'h07, 1'b0, KIND_PASS}, // smallest size that holds a PCR
		'{8'h10, 1'b0, 1'b1, 8'h10, 1'b0, KIND_PASS}, // PCR flag
		// all-ones PCR base: +1 wraps it to zero
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		// PES header expected at 12, but the next packet starts here
		'{8'h47, 1'b1, 1'b1, 8'h47, 1'b1, KIND_PASS},
		'{8'h40, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'h20, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS}, // adaptation field only
		'{8'hB7, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS}, // longest adaptation field
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS}, // every flag set
		'{8'h12, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS}, // PCR bytes, held
		'{8'h34, 1'b0, 1'b0, 8'h00, 1'b0, KIND_PASS},
		// early packet start: held PCR bytes come out plain first
		'{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, KIND_PASS},
		'{8'h80, 1'b0, 1'b1, 8'h80, 1'b0, KIND_PASS}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            in_byte;
	logic                  packet_begin;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_byte;
	logic                  out_begin;
	logic                  run_last;
	logic [1:0]            field_kind;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor state
	logic [31:0] ofs_all;
	logic [31:0] ofs_pts;
	logic [7:0]  pkt_pos;
	logic        pusi_seen;
	logic        af_seen;
	logic [8:0]  af_span;
	logic [8:0]  pes_at_pos;
	logic        has_pcr;
	logic        has_pts;
	logic        has_dts;
	logic [7:0]  stash [HOLD_DEPTH];
	logic [2:0]  stash_n;
	kind_t       stash_kind;

	out_rec_t    step_out[$];       // output bytes caused by the current input byte
	out_rec_t    expected_bytes[$]; // output bytes still owed by the block

	int          mismatches   = 0;
	int          stall_cycles = 0;
	int          src_idle_pct;
	int          sink_idle_pct;
	int          stim_count;
	bit          prev_full;

	ts_timestamp_restamper u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.packet_begin (packet_begin),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_begin    (out_begin),
		.run_last     (run_last),
		.field_kind   (field_kind),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void emit(input logic [7:0] b, input logic first, input kind_t k);
		out_rec_t r;
		r.data  = b;
		r.first = first;
		r.last  = 1'b0;
		r.kind  = k;
		step_out.push_back(r);
	endfunction

	// Send any held field bytes out untouched.
	function automatic void dump_stash();
		for (int i = 0; i < stash_n; i++)
			emit(stash[i], 1'b0, KIND_PASS);
		stash_n    = '0;
		stash_kind = KIND_PASS;
	endfunction

	// Advance the parser by one stream byte and collect what it sends out.
	function automatic void restamp_byte(input logic [7:0] b, input logic beg);
		int          idx;
		int          p;
		int          start;
		int          len;
		kind_t       k;
		logic [32:0] base;
		logic [32:0] off;

		step_out.delete();
		if (beg || pkt_pos >= PACKET_BYTES)
			pkt_pos = '0;
		idx = int'(pkt_pos);

		if (idx == 0) begin
			if (stash_n != 0)
				dump_stash();
			pusi_seen  = 1'b0;
			af_seen    = 1'b0;
			af_span    = '0;
			pes_at_pos = '0;
			has_pcr    = 1'b0;
			has_pts    = 1'b0;
			has_dts    = 1'b0;
		end

		// header bytes
		case (idx)
			1: begin
				if (b[6])
					pusi_seen = 1'b1;
			end
			3: begin
				if (b[5])
					af_seen = 1'b1;
				else if (pusi_seen)
					pes_at_pos = 9'd4;
			end
			4: begin
				if (af_seen) begin
					af_span = 9'(int'(b) + 1);
					if (pusi_seen && 5 + int'(b) + 9 < PACKET_BYTES)
						pes_at_pos = 9'(5 + int'(b));
				end
			end
			5: begin
				if (af_seen && b[4] && af_span >= 9'd8)
					has_pcr = 1'b1;
			end
			default: ;
		endcase

		// PES prefix and the PTS/DTS flags
		p = int'(pes_at_pos);
		if (p != 0) begin
			if ((idx == p || idx == p + 1) && b != 8'h00)
				pes_at_pos = '0;
			else if (idx == p + 2 && b != 8'h01)
				pes_at_pos = '0;
			else if (idx == p + 7 && b[7] && p + 14 <= PACKET_BYTES) begin
				has_pts = 1'b1;
				if (b[6] && p + 19 <= PACKET_BYTES)
					has_dts = 1'b1;
			end
		end

		k     = KIND_PASS;
		start = 0;
		len   = 0;
		if (has_pcr && idx >= 6 && idx < 12) begin
			k     = KIND_PCR;
			start = 6;
			len   = 6;
		end else if (p != 0 && has_pts && idx >= p + 9 && idx < p + 14) begin
			k     = KIND_PTS;
			start = p + 9;
			len   = 5;
		end else if (p != 0 && has_dts && idx >= p + 14 && idx < p + 19) begin
			k     = KIND_DTS;
			start = p + 14;
			len   = 5;
		end

		if (stash_n != 0 && (stash_kind != k || idx == start))
			dump_stash();

		if (k != KIND_PASS && stash_n < HOLD_DEPTH) begin
			stash_kind     = k;
			stash[stash_n] = b;
			stash_n++;
			if (stash_n == len) begin
				// 33-bit base arithmetic wraps on its own
				off = {ofs_all[31], ofs_all};
				if (k == KIND_PTS)
					off = off + {ofs_pts[31], ofs_pts};
				if (k == KIND_PCR) begin
					base = {stash[0], stash[1], stash[2], stash[3], stash[4][7]} + off;
					stash[0]    = base[32:25];
					stash[1]    = base[24:17];
					stash[2]    = base[16:9];
					stash[3]    = base[8:1];
					stash[4][7] = base[0];
				end else begin
					base = {stash[0][3:1], stash[1], stash[2][7:1], stash[3],
						stash[4][7:1]} + off;
					stash[0][3:1] = base[32:30];
					stash[1]      = base[29:22];
					stash[2][7:1] = base[21:15];
					stash[3]      = base[14:7];
					stash[4][7:1] = base[6:0];
				end
				for (int i = 0; i < len; i++)
					emit(stash[i], 1'b0, k);
				stash_n    = '0;
				stash_kind = KIND_PASS;
			end
		end else begin
			emit(b, idx == 0, KIND_PASS);
		end

		pkt_pos = 8'(idx + 1);
		if (pkt_pos >= PACKET_BYTES)
			pkt_pos = '0;
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Drive one byte from a falling edge, hold it until accepted, then predict.
	// Returns at the falling edge after the accepting edge.
	task automatic send_byte(input stim_row_t row);
		out_rec_t rec;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		in_byte      <= row.b;
		packet_begin <= row.beg;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		restamp_byte(row.b, row.beg);
		if (row.typed) begin
			rec = '{row.x_byte, row.x_first, 1'b1, row.x_kind};
			expected_bytes.push_back(rec);
		end else begin
			foreach (step_out[i])
				expected_bytes.push_back(step_out[i]);
		end
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed byte is out and the pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup phase, access phase, then back to idle.
	task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_TIME_OFFSET: ofs_all = v;
			REG_PTS_SHIFT:   ofs_pts = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Build one packet with random content around a mostly well-formed header.
	// Most packets are cut short by the next packet start; a PES header near
	// the end of the packet forces a full-length one.
	task automatic send_packet(input bit force_full);
		logic [7:0] pkt [PACKET_BYTES];
		int         af_len;
		int         pes_at;
		int         n_bytes;
		bit         with_af;
		stim_row_t  row;

		foreach (pkt[i])
			pkt[i] = 8'($urandom());
		if ($urandom_range(0, 15) != 0)
			pkt[0] = 8'h47;
		pkt[1][6] = ($urandom_range(0, 7) != 0);
		with_af   = force_full || ($urandom_range(0, 1) == 1);
		pkt[3][5] = with_af;

		if (force_full)
			af_len = $urandom_range(160, 173); // PES header in the last 24 bytes
		else if ($urandom_range(0, 15) == 0)
			af_len = $urandom_range(0, 255);
		else if ($urandom_range(0, 3) == 0)
			af_len = $urandom_range(0, 6);     // too short to hold a PCR
		else
			af_len = $urandom_range(7, 14);
		pes_at = with_af ? 5 + af_len : 4;
		if (with_af) begin
			pkt[4]    = 8'(af_len);
			pkt[5][4] = ($urandom_range(0, 3) != 0);
		end

		// well-formed start prefix most of the time, random flag pair
		if ($urandom_range(0, 7) != 0 && pes_at + 9 < PACKET_BYTES) begin
			pkt[pes_at]          = 8'h00;
			pkt[pes_at + 1]      = 8'h00;
			pkt[pes_at + 2]      = 8'h01;
			pkt[pes_at + 7][7:6] = 2'($urandom());
		end

		if (force_full || pes_at > 150)
			n_bytes = PACKET_BYTES;
		else if ($urandom_range(0, 3) == 0)
			n_bytes = pes_at + $urandom_range(4, 18);  // cut inside the timestamps
		else
			n_bytes = pes_at + $urandom_range(19, 26);

		for (int i = 0; i < n_bytes; i++) begin
			row   = '0;
			row.b = pkt[i];
			if (i == 0)
				row.beg = prev_full ? 1'($urandom()) : ($urandom_range(0, 15) != 0);
			else
				row.beg = ($urandom_range(0, 199) == 0);
			send_byte(row);
		end
		prev_full  = (n_bytes == PACKET_BYTES);
		stim_count += n_bytes;
	endtask

	// Receiver: stall at random, decided at each falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);

	// ------------------------------------------------------------------------
	// Output check: compare every output transaction with the oldest owed byte
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_rec_t got;
		out_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_byte, out_begin, run_last, field_kind};
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected output byte %02h begin %0b last %0b kind %0d",
						$time, got.data, got.first, got.last, got.kind);
			end else begin
				want = expected_bytes.pop_front();
				if (got.data !== want.data || got.first !== want.first ||
					got.last !== want.last || got.kind !== want.kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: byte mismatch, expected %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
							$time, want.data, want.first, want.last, want.kind,
							got.data, got.first, got.last, got.kind);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_byte       = '0;
		packet_begin  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		src_idle_pct  = 15;
		sink_idle_pct = 83;
		prev_full     = 1'b0;

		// predictor starts from the reset state
		ofs_all    = '0;
		ofs_pts    = '0;
		pkt_pos    = '0;
		pusi_seen  = 1'b0;
		af_seen    = 1'b0;
		af_span    = '0;
		pes_at_pos = '0;
		has_pcr    = 1'b0;
		has_pts    = 1'b0;
		has_dts    = 1'b0;
		stash_n    = '0;
		stash_kind = KIND_PASS;

		// hold reset, release on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: +1 wraps an all-ones base, -1 cancels it on the PTS
		write_reg(REG_TIME_OFFSET, 32'h0000_0001);
		write_reg(REG_PTS_SHIFT, 32'hFFFF_FFFF);
		for (int i = 0; i < $size(DIRECTED); i++)
			send_byte(DIRECTED[i]);
		settle();

		// random part in three phases: sender mostly busy and receiver mostly
		// stalled, then the reverse, then both at full rate
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 1) ? 83 : (phase == 0) ? 15 : 0;
			sink_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 15 : 0;
			write_reg(REG_TIME_OFFSET, (phase == 0) ? 32'h7FFF_FFFF :
				(phase == 1) ? 32'h8000_0000 : $urandom());
			write_reg(REG_PTS_SHIFT, (phase == 0) ? 32'h8000_0000 :
				(phase == 1) ? 32'h7FFF_FFFF : $urandom());
			stim_count = 0;
			for (int n = 0; stim_count < PHASE_ITEMS; n++) begin
				// one full packet in the last phase reaches the packet-end cases
				send_packet(phase == 2 && n == 0);
				// pause the sender until the block has caught up
				if (phase == 0 && (n == 1 || $urandom_range(0, 7) == 0))
					settle();
			end
			// start a new packet so no field bytes stay held across the register writes
			send_byte('{8'h47, 1'b1, 1'b0, 8'h00, 1'b0, KIND_PASS});
			settle();
		end

		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
